// File: sv/ccsc_pkg.sv
// Package for the calendar clock second counter.
// Holds field widths, command and relation codes, calendar constants and payload types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ccsc_pkg;

	localparam int YEAR_W = 14;
	localparam int MON_W  = 4;
	localparam int DAY_W  = 5;
	localparam int HOUR_W = 5;
	localparam int MIN_W  = 6;
	localparam int SEC_W  = 6;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_LOAD = 2'd1,
		CMD_CMP  = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REL_LESS    = 2'd0,
		REL_EQUAL   = 2'd1,
		REL_GREATER = 2'd2
	} rel_t;

	localparam logic [SEC_W-1:0]  LAST_SECOND = SEC_W'(59);
	localparam logic [MIN_W-1:0]  LAST_MINUTE = MIN_W'(59);
	localparam logic [HOUR_W-1:0] LAST_HOUR   = HOUR_W'(23);
	localparam logic [MON_W-1:0]  LAST_MONTH  = MON_W'(12);
	localparam logic [YEAR_W-1:0] LAST_YEAR   = YEAR_W'(9999);

	localparam logic [MON_W-1:0] MON_FEB = MON_W'(2);
	localparam logic [MON_W-1:0] MON_APR = MON_W'(4);
	localparam logic [MON_W-1:0] MON_JUN = MON_W'(6);
	localparam logic [MON_W-1:0] MON_SEP = MON_W'(9);
	localparam logic [MON_W-1:0] MON_NOV = MON_W'(11);

	localparam logic [DAY_W-1:0] DAYS_28 = DAY_W'(28);
	localparam logic [DAY_W-1:0] DAYS_29 = DAY_W'(29);
	localparam logic [DAY_W-1:0] DAYS_30 = DAY_W'(30);
	localparam logic [DAY_W-1:0] DAYS_31 = DAY_W'(31);

	// A year is a multiple of 25 exactly when its product with the inverse of 25
	// modulo 2^14 does not exceed floor((2^14 - 1) / 25).
	localparam logic [YEAR_W-1:0] INV25 = YEAR_W'(7209);
	localparam logic [YEAR_W-1:0] LIM25 = YEAR_W'(((1 << YEAR_W) - 1) / 25);

	typedef struct packed {
		logic [YEAR_W-1:0] year;
		logic [MON_W-1:0]  month;
		logic [DAY_W-1:0]  day;
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic [SEC_W-1:0]  second;
	} time_t;

	localparam time_t TIME_RESET = '{
		year:   '0,
		month:  MON_W'(1),
		day:    DAY_W'(1),
		hour:   '0,
		minute: '0,
		second: '0
	};

	typedef struct packed {
		time_t t;
		rel_t  rel;
	} rsp_t;

endpackage

`default_nettype wire

// File: sv/ccsc_if.sv
// Request and response channel interfaces for the calendar clock second counter.
// Depends on ccsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ccsc_req_if;
	import ccsc_pkg::*;

	logic              valid;
	logic              ready;
	cmd_t              cmd;
	logic [YEAR_W-1:0] in_year;
	logic [MON_W-1:0]  in_month;
	logic [DAY_W-1:0]  in_day;
	logic [HOUR_W-1:0] in_hour;
	logic [MIN_W-1:0]  in_minute;
	logic [SEC_W-1:0]  in_second;

	modport source(
		output valid, cmd, in_year, in_month, in_day, in_hour, in_minute, in_second,
		input  ready
	);
	modport sink(
		input  valid, cmd, in_year, in_month, in_day, in_hour, in_minute, in_second,
		output ready
	);
endinterface

interface ccsc_rsp_if;
	import ccsc_pkg::*;

	logic              valid;
	logic              ready;
	logic [YEAR_W-1:0] cur_year;
	logic [MON_W-1:0]  cur_month;
	logic [DAY_W-1:0]  cur_day;
	logic [HOUR_W-1:0] cur_hour;
	logic [MIN_W-1:0]  cur_minute;
	logic [SEC_W-1:0]  cur_second;
	rel_t              relation;

	modport source(
		output valid, cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
		output relation,
		input  ready
	);
	modport sink(
		input  valid, cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
		input  relation,
		output ready
	);
endinterface

`default_nettype wire

// File: sv/ccsc_tick.sv
// One-second advance of a calendar time with Gregorian leap years.
// Purely combinational. Depends on ccsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccsc_tick (
	input  ccsc_pkg::time_t cur,
	output ccsc_pkg::time_t nxt
);
	import ccsc_pkg::*;

	logic [YEAR_W-1:0] prod25;
	logic              div4;
	logic              div16;
	logic              div25;
	logic              leap;
	logic [DAY_W-1:0]  mon_len;

	assign prod25 = YEAR_W'(cur.year * INV25);
	assign div4   = (cur.year[1:0] == 2'b00);
	assign div16  = (cur.year[3:0] == 4'b0000);
	assign div25  = (prod25 <= LIM25);
	assign leap   = (div4 && !div25) || (div16 && div25);

	always_comb begin
		case (cur.month)
			MON_APR, MON_JUN, MON_SEP, MON_NOV: mon_len = DAYS_30;
			MON_FEB: mon_len = leap ? DAYS_29 : DAYS_28;
			default: mon_len = DAYS_31;
		endcase
	end

	always_comb begin
		nxt = cur;
		if (cur.second < LAST_SECOND) begin
			nxt.second = cur.second + SEC_W'(1);
		end else begin
			nxt.second = '0;
			if (cur.minute < LAST_MINUTE) begin
				nxt.minute = cur.minute + MIN_W'(1);
			end else begin
				nxt.minute = '0;
				if (cur.hour < LAST_HOUR) begin
					nxt.hour = cur.hour + HOUR_W'(1);
				end else begin
					nxt.hour = '0;
					if (cur.day < mon_len) begin
						nxt.day = cur.day + DAY_W'(1);
					end else begin
						nxt.day = DAY_W'(1);
						if (cur.month < LAST_MONTH) begin
							nxt.month = cur.month + MON_W'(1);
						end else begin
							nxt.month = MON_W'(1);
							if (cur.year < LAST_YEAR) begin
								nxt.year = cur.year + YEAR_W'(1);
							end else begin
								nxt.year = '0;
							end
						end
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/ccsc_cmp.sv
// Ordering of the stored time against a given time, year first, second last.
// Purely combinational. Depends on ccsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccsc_cmp (
	input  ccsc_pkg::time_t a,
	input  ccsc_pkg::time_t b,
	output ccsc_pkg::rel_t  rel
);
	import ccsc_pkg::*;

	always_comb begin
		if (a.year != b.year) begin
			rel = (a.year < b.year) ? REL_LESS : REL_GREATER;
		end else if (a.month != b.month) begin
			rel = (a.month < b.month) ? REL_LESS : REL_GREATER;
		end else if (a.day != b.day) begin
			rel = (a.day < b.day) ? REL_LESS : REL_GREATER;
		end else if (a.hour != b.hour) begin
			rel = (a.hour < b.hour) ? REL_LESS : REL_GREATER;
		end else if (a.minute != b.minute) begin
			rel = (a.minute < b.minute) ? REL_LESS : REL_GREATER;
		end else if (a.second != b.second) begin
			rel = (a.second < b.second) ? REL_LESS : REL_GREATER;
		end else begin
			rel = REL_EQUAL;
		end
	end

endmodule

`default_nettype wire

// File: sv/calendar_clock_second_counter.sv
// Calendar clock second counter: year, month, day, hour, minute and second.
//
// Each request on req carries a command and a time. A tick advances the stored
// time by one second, a load replaces it, and a compare reports on rsp whether
// the stored time is less than, equal to or greater than the given one.
// Every request produces exactly one response on rsp carrying the stored time
// after that request and the compare relation, which is less for all other
// commands.
// The response is registered in the cycle after the request is accepted. One
// request is accepted per cycle unless rsp stalls; the tick carry chain and the
// compare sit between the stored time and the response register.
// The response register holds its contents while rsp is stalled, and req is
// ready whenever that register is empty or is being read in the same cycle.
// Reset sets the time to year 0, January 1, 00:00:00 and empties the response
// register.
// Depends on ccsc_pkg, ccsc_if, ccsc_tick and ccsc_cmp.
`timescale 1ns / 1ps
`default_nettype none

module calendar_clock_second_counter (
	input  logic        clk,
	input  logic        arst_n,
	ccsc_req_if.sink    req,
	ccsc_rsp_if.source  rsp
);
	import ccsc_pkg::*;

	time_t time_q;
	time_t req_time;
	time_t tick_time;
	rel_t  cmp_rel;
	rsp_t  rsp_q;
	logic  rsp_valid_q;
	logic  accept;

	assign req_time = '{
		year:   req.in_year,
		month:  req.in_month,
		day:    req.in_day,
		hour:   req.in_hour,
		minute: req.in_minute,
		second: req.in_second
	};

	ccsc_tick u_tick (
		.cur(time_q),
		.nxt(tick_time)
	);

	ccsc_cmp u_cmp (
		.a  (time_q),
		.b  (req_time),
		.rel(cmp_rel)
	);

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= TIME_RESET;
		end else if (accept) begin
			case (req.cmd)
				CMD_TICK: time_q <= tick_time;
				CMD_LOAD: time_q <= req_time;
				default:  time_q <= time_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req.ready) begin
			rsp_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			case (req.cmd)
				CMD_TICK: begin
					rsp_q.t   <= tick_time;
					rsp_q.rel <= REL_LESS;
				end
				CMD_LOAD: begin
					rsp_q.t   <= req_time;
					rsp_q.rel <= REL_LESS;
				end
				CMD_CMP: begin
					rsp_q.t   <= time_q;
					rsp_q.rel <= cmp_rel;
				end
				default: begin
					rsp_q.t   <= time_q;
					rsp_q.rel <= REL_LESS;
				end
			endcase
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.cur_year   = rsp_q.t.year;
	assign rsp.cur_month  = rsp_q.t.month;
	assign rsp.cur_day    = rsp_q.t.day;
	assign rsp.cur_hour   = rsp_q.t.hour;
	assign rsp.cur_minute = rsp_q.t.minute;
	assign rsp.cur_second = rsp_q.t.second;
	assign rsp.relation   = rsp_q.rel;

endmodule

`default_nettype wire
